>>> hw/rtl/frsd_pkg.sv
// Shared types and constants of the run-length sprite decoder.
`timescale 1ns / 1ps
`default_nettype none

package frsd_pkg;

  // Port field widths
  localparam int COLUMN_W    = 9;
  localparam int ROW_W       = 10;
  localparam int PIXEL_W     = 8;
  localparam int BYTE_W      = 8;
  localparam int COUNT_W     = 7;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 10;

  // Register indexes on the config port
  localparam logic [CFG_INDEX_W-1:0] REG_ROW_WIDTH = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_USE_LIGHT = 8'd1;

  localparam logic [CFG_DATA_W-1:0] ROW_WIDTH_RESET = 10'd32;

  // Control byte magnitudes above this are fills, at or below are copies
  localparam logic [BYTE_W-1:0] SPLIT = 8'd65;

  // Op queue and light table sizes
  localparam int QUEUE_DEPTH = 4;
  localparam int LIGHT_DEPTH = 256;

  // Stream parser run state
  typedef enum logic [1:0] {
    RUN_IDLE,
    RUN_COPY,
    RUN_FILL
  } run_kind_t;

  // Work handed from parser to pixel engine
  typedef enum logic [1:0] {
    OP_EMIT,   // emit value count times
    OP_SKIP,   // advance count transparent pixels
    OP_CLEAR,  // no pixels, only the end-of-sprite home move
    OP_TABLE   // light table write
  } op_kind_t;

  typedef struct packed {
    op_kind_t            kind;
    logic [BYTE_W-1:0]   value;
    logic [BYTE_W-1:0]   index;
    logic [COUNT_W-1:0]  count;
    logic                eos;
  } op_t;

  typedef struct packed {
    logic              command;
    logic [BYTE_W-1:0] data;
    logic [BYTE_W-1:0] table_index;
    logic              end_of_sprite;
  } in_item_t;

  typedef struct packed {
    logic [COLUMN_W-1:0] column;
    logic [ROW_W-1:0]    row;
    logic [PIXEL_W-1:0]  pixel;
    logic                last;
  } out_item_t;

endpackage

`default_nettype wire

>>> hw/rtl/frsd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module frsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/frsd_front.sv
// Stream parser: accepts input transactions, tracks run state, queues ops.
`timescale 1ns / 1ps
`default_nettype none

module frsd_front import frsd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  input  logic     q_full,
  output logic     push,
  output op_t      push_op
);

  run_kind_t          run_kind, run_kind_next;
  logic [COUNT_W-1:0] run_left, run_left_next;
  logic               acc;
  logic [BYTE_W-1:0]  mag;
  logic [COUNT_W-1:0] left_dec;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_kind <= RUN_IDLE;
      run_left <= '0;
    end else begin
      run_kind <= run_kind_next;
      run_left <= run_left_next;
    end
  end

  // Classify each accepted byte
  always_comb begin
    in_ready      = !q_full;
    acc           = in_valid && in_ready;
    mag           = BYTE_W'(9'd256 - {1'b0, in_item.data});
    left_dec      = run_left - COUNT_W'(1);
    run_kind_next = run_kind;
    run_left_next = run_left;
    push          = 1'b0;
    push_op.kind  = OP_CLEAR;
    push_op.value = in_item.data;
    push_op.index = in_item.table_index;
    push_op.count = '0;
    push_op.eos   = in_item.end_of_sprite;

    if (acc) begin
      if (in_item.command) begin
        push         = 1'b1;
        push_op.kind = OP_TABLE;
        push_op.eos  = 1'b0;
      end else begin
        case (run_kind)
          RUN_COPY: begin
            push          = 1'b1;
            push_op.kind  = OP_EMIT;
            push_op.count = COUNT_W'(1);
            run_left_next = left_dec;
            if (left_dec == '0) begin
              run_kind_next = RUN_IDLE;
            end
          end
          RUN_FILL: begin
            push          = 1'b1;
            push_op.kind  = OP_EMIT;
            push_op.count = run_left;
            run_left_next = '0;
            run_kind_next = RUN_IDLE;
          end
          default: begin
            if (in_item.data == '0) begin
              // zero control byte: nothing but a possible end of sprite
              push = in_item.end_of_sprite;
            end else if (!in_item.data[BYTE_W-1]) begin
              push          = 1'b1;
              push_op.kind  = OP_SKIP;
              push_op.count = in_item.data[COUNT_W-1:0];
            end else begin
              push = in_item.end_of_sprite;
              if (mag > SPLIT) begin
                run_kind_next = RUN_FILL;
                run_left_next = COUNT_W'(mag - SPLIT);
              end else begin
                run_kind_next = RUN_COPY;
                run_left_next = COUNT_W'(mag);
              end
            end
          end
        endcase
        if (in_item.end_of_sprite) begin
          run_kind_next = RUN_IDLE;
          run_left_next = '0;
        end
      end
    end
  end

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    run_kind == RUN_IDLE |-> run_left == '0)
    else $error("run count left over while waiting for a control byte");

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    run_kind == RUN_FILL |-> (run_left != '0 && run_left < COUNT_W'(64)))
    else $error("fill run count out of range");

endmodule

`default_nettype wire

>>> hw/rtl/frsd_queue.sv
// Short op queue between the stream parser and the pixel engine.
`timescale 1ns / 1ps
`default_nettype none

module frsd_queue import frsd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  push_op,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output op_t  head_op
);

  localparam int AW = $clog2(QUEUE_DEPTH);

  op_t           slots [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + (AW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  assign full       = (count == (AW+1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_op    = slots[rd_ptr];

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("op queue popped while empty");

endmodule

`default_nettype wire

>>> hw/rtl/frsd_back.sv
// Pixel engine: runs queued ops, tracks position, owns light table and output.
`timescale 1ns / 1ps
`default_nettype none

module frsd_back import frsd_pkg::*; #(
  parameter int MAX_ROW_WIDTH = 512,
  parameter int ROW_LIMIT     = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [CFG_DATA_W-1:0] row_width,
  input  logic                  use_light,
  input  logic                  q_valid,
  input  op_t                   q_op,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_item
);

  localparam int EW    = $clog2(MAX_ROW_WIDTH + 1);
  localparam int COL_W = $clog2(MAX_ROW_WIDTH);
  localparam int RW    = $clog2(ROW_LIMIT);
  localparam int CW    = (EW > COUNT_W) ? EW : COUNT_W;

  logic               cur_valid;
  op_t                cur;
  logic [COL_W-1:0]   col, col_next;
  logic [RW-1:0]      row, row_next;
  logic [COUNT_W-1:0] count_next;
  logic [COL_W-1:0]   o_col;
  logic [RW-1:0]      o_row;
  logic [PIXEL_W-1:0] o_pix;
  logic               o_last;
  logic [PIXEL_W-1:0] light_rdata;

  logic [EW-1:0]      eff;
  logic [EW-1:0]      col_inc;
  logic [EW-1:0]      to_edge;
  logic [RW-1:0]      row_inc;
  logic               can_issue, issue, done, ram_we;

  // Effective row width, clamped to 1..MAX_ROW_WIDTH
  always_comb begin
    if (row_width == '0) begin
      eff = EW'(1);
    end else if (int'(row_width) > MAX_ROW_WIDTH) begin
      eff = EW'(MAX_ROW_WIDTH);
    end else begin
      eff = EW'(row_width);
    end
  end

  // Position helpers
  always_comb begin
    col_inc = EW'(col) + EW'(1);
    row_inc = (row == RW'(ROW_LIMIT - 1)) ? '0 : row + RW'(1);
    if (EW'(col) >= eff) begin
      to_edge = EW'(1);
    end else begin
      to_edge = eff - EW'(col);
    end
  end

  // One step of the current op
  always_comb begin
    can_issue  = !out_valid || out_ready;
    issue      = 1'b0;
    done       = 1'b0;
    ram_we     = 1'b0;
    col_next   = col;
    row_next   = row;
    count_next = cur.count;

    if (cur_valid) begin
      case (cur.kind)
        OP_EMIT: begin
          if (can_issue) begin
            issue      = 1'b1;
            count_next = cur.count - COUNT_W'(1);
            done       = (cur.count == COUNT_W'(1));
            if (col_inc >= eff) begin
              col_next = '0;
              row_next = row_inc;
            end else begin
              col_next = COL_W'(col_inc);
            end
          end
        end
        OP_SKIP: begin
          // move to the row edge or to the end of the skip, whichever is first
          if (CW'(cur.count) >= CW'(to_edge)) begin
            col_next   = '0;
            row_next   = row_inc;
            count_next = cur.count - COUNT_W'(to_edge);
          end else begin
            col_next   = COL_W'(CW'(col) + CW'(cur.count));
            count_next = '0;
          end
          done = (count_next == '0);
        end
        OP_TABLE: begin
          ram_we = 1'b1;
          done   = 1'b1;
        end
        default: begin
          done = 1'b1;
        end
      endcase
      if (done && cur.eos) begin
        col_next = '0;
        row_next = '0;
      end
    end

    pop = q_valid && (!cur_valid || done);
  end

  // Current op and position
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      col       <= '0;
      row       <= '0;
    end else begin
      col <= col_next;
      row <= row_next;
      if (pop) begin
        cur_valid <= 1'b1;
      end else if (done) begin
        cur_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_op;
    end else begin
      cur.count <= count_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (issue) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      o_col  <= col;
      o_row  <= row;
      o_pix  <= cur.value;
      o_last <= done;
    end
  end

  // Light table; read only on issue so the data holds through a stall
  frsd_ram #(
    .WIDTH (PIXEL_W),
    .DEPTH (LIGHT_DEPTH)
  ) u_light (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cur.index),
    .wdata (cur.value),
    .re    (issue),
    .raddr (cur.value),
    .rdata (light_rdata)
  );

  always_comb begin
    out_item.column = COLUMN_W'(o_col);
    out_item.row    = ROW_W'(o_row);
    out_item.pixel  = use_light ? light_rdata : o_pix;
    out_item.last   = o_last;
  end

  a_eos_home: assert property (@(posedge clk) disable iff (rst)
    cur_valid && done && cur.eos |=> (col == '0 && row == '0))
    else $error("position not cleared after end of sprite");

  a_emit_count: assert property (@(posedge clk) disable iff (rst)
    cur_valid && cur.kind == OP_EMIT |-> cur.count != '0)
    else $error("emit op with zero count");

endmodule

`default_nettype wire

>>> hw/rtl/fill_rle_sprite_decoder_unit.sv
// Run-length sprite decoder top level: config registers, parser, queue, engine.
//
// Input channel (in_valid/in_ready/in_item): one sprite stream byte or one
// light table write per transaction. Output channel (out_valid/out_ready/
// out_item): one pixel write (column, row, pixel, last) per transaction.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready;
// index 0 is row_width, index 1 is use_light, other indexes are ignored.
// The parser takes one byte per cycle while the four-entry op queue has room.
// The pixel engine emits one pixel per cycle while the output is not stalled: a
// copy byte gives one pixel, a fill byte gives its run length (1 to 63 pixels),
// a skip moves to each row edge that it crosses in turn and then, if it stops
// inside a row, to that point, and a table write is a single step.
// With the engine idle, an accepted byte's first pixel passes through the queue
// slot, the current op register and the output register to the output.
// When out_ready is low the output register holds and the engine stalls; the
// queue then fills and in_ready drops. Reset clears position, run state and
// all valid flags, and sets row_width to 32 and use_light to 0. The light
// table is not cleared: every entry must be written before it is used.
`timescale 1ns / 1ps
`default_nettype none

module fill_rle_sprite_decoder_unit import frsd_pkg::*; #(
  parameter int MAX_ROW_WIDTH = 512,
  parameter int ROW_LIMIT     = 1024
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_item_t               in_item,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_item_t              out_item,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [CFG_DATA_W-1:0] row_width;
  logic                  use_light;
  logic                  q_full, push, pop, q_valid;
  op_t                   push_op, q_op;

  // Config registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width <= ROW_WIDTH_RESET;
      use_light <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ROW_WIDTH: row_width <= cfg_data;
        REG_USE_LIGHT: use_light <= cfg_data[0];
        default: ;
      endcase
    end
  end

  frsd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_full   (q_full),
    .push     (push),
    .push_op  (push_op)
  );

  frsd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_op    (push_op),
    .full       (q_full),
    .pop        (pop),
    .head_valid (q_valid),
    .head_op    (q_op)
  );

  frsd_back #(
    .MAX_ROW_WIDTH (MAX_ROW_WIDTH),
    .ROW_LIMIT     (ROW_LIMIT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .row_width (row_width),
    .use_light (use_light),
    .q_valid   (q_valid),
    .q_op      (q_op),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire
